// ----- design/text_extent_measurer_unit_defines.svh -----
// ---------------------------------------------------------------------------
// text_extent_measurer_unit_defines.svh
// Assertion macros for the text extent measurer.
// ---------------------------------------------------------------------------
`ifndef TEXT_EXTENT_MEASURER_UNIT_DEFINES_SVH
`define TEXT_EXTENT_MEASURER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define TEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text extent measurer: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define TEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text extent measurer: next-cycle check failed");

`else

`define TEM_ASSERT_NOW(lbl, ante, cons)
`define TEM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/tem_pkg.sv -----
// ---------------------------------------------------------------------------
// tem_pkg
// Shared constants, codes and types of the text extent measurer.
// ---------------------------------------------------------------------------
`default_nettype none

package tem_pkg;

  // Glyph table geometry
  localparam int GLYPH_COUNT = 256;
  localparam int IDX_W       = $clog2(GLYPH_COUNT);

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Saturation limit
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Input action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TEXT  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Configuration register indexes
  localparam int          CFG_IDX_W         = 1;
  localparam logic [0:0]  CFG_SPACE_ADVANCE = 1'b0;
  localparam logic [0:0]  CFG_LINE_HEIGHT   = 1'b1;

  // Character codes
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_CARET   = 8'h5E;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;

  // Kind of queued item
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_TEXT,
    KIND_END
  } kind_t;

  // Class of a text byte
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NEWLINE,
    CLS_SPACE,
    CLS_TAB,
    CLS_CARET,
    CLS_DIGIT
  } cls_t;

  // Classified item carried by the queue
  typedef struct packed {
    kind_t      kind;
    cls_t       cls;
    logic [7:0] code;
    logic [7:0] adv;
    logic       pres;
  } item_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic end_in_b;
    logic stall;
  } bstat_t;

endpackage

`default_nettype wire

// ----- design/tem_front.sv -----
// ---------------------------------------------------------------------------
// tem_front
// Accepts input items, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tem_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [23:0]    in_tdata,  // char_code[7:0], glyph_advance[15:8],
                                          // glyph_present[16], zero pad
  input  wire logic [1:0]     in_tuser,  // action[1:0]
  output logic                q_valid,
  output tem_pkg::item_t      q_item,
  input  wire logic           q_pop
);

  tem_pkg::item_t                 cls_item;
  logic                           push;
  tem_pkg::item_t                 q_mem_r [tem_pkg::Q_DEPTH];
  logic [tem_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tem_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tem_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  // Classify the incoming item
  always_comb begin
    cls_item.code = in_tdata[7:0];
    cls_item.adv  = in_tdata[15:8];
    cls_item.pres = in_tdata[16];
    case (in_tuser)
      tem_pkg::ACT_WRITE: cls_item.kind = tem_pkg::KIND_WRITE;
      tem_pkg::ACT_TEXT:  cls_item.kind = tem_pkg::KIND_TEXT;
      default:            cls_item.kind = tem_pkg::KIND_END;
    endcase
    if (in_tdata[7:0] == tem_pkg::CHR_NEWLINE) begin
      cls_item.cls = tem_pkg::CLS_NEWLINE;
    end else if (in_tdata[7:0] == tem_pkg::CHR_SPACE) begin
      cls_item.cls = tem_pkg::CLS_SPACE;
    end else if (in_tdata[7:0] == tem_pkg::CHR_TAB) begin
      cls_item.cls = tem_pkg::CLS_TAB;
    end else if (in_tdata[7:0] == tem_pkg::CHR_CARET) begin
      cls_item.cls = tem_pkg::CLS_CARET;
    end else if (in_tdata[7:0] inside {[tem_pkg::CHR_ZERO:tem_pkg::CHR_NINE]}) begin
      cls_item.cls = tem_pkg::CLS_DIGIT;
    end else begin
      cls_item.cls = tem_pkg::CLS_OTHER;
    end
  end

  // Accept while the queue has room; drop the unused action code
  assign in_tready = (count_r != tem_pkg::Q_CNT_W'(tem_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready && (in_tuser != tem_pkg::ACT_NONE);

  // Queue head
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + tem_pkg::Q_CNT_W'(push) - tem_pkg::Q_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the item payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/tem_back.sv -----
// ---------------------------------------------------------------------------
// tem_back
// Glyph table, width and height accumulators and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tem_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire tem_pkg::item_t q_item,
  output logic                q_pop,
  input  wire logic [7:0]     space_advance,
  input  wire logic [7:0]     line_height,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [31:0]         out_tdata,   // total_width[15:0], total_height[31:16]
  output tem_pkg::bstat_t     bstat
);

  localparam logic [tem_pkg::IDX_W-1:0] CARET_IDX = tem_pkg::CHR_CARET[tem_pkg::IDX_W-1:0];

  // Glyph store
  logic [7:0]                     adv_mem [tem_pkg::GLYPH_COUNT];
  logic [tem_pkg::GLYPH_COUNT-1:0] present_r;
  logic [7:0]                     caret_adv_r;

  // Table access stage
  logic                           adv;
  logic                           in_rng;
  logic [tem_pkg::IDX_W-1:0]      idx;
  logic                           do_write;
  logic [7:0]                     caret_w;

  // Accumulate stage
  logic                           b_valid_r;
  tem_pkg::kind_t                 b_kind_r;
  tem_pkg::cls_t                  b_cls_r;
  logic                           b_pres_r;
  logic [7:0]                     b_caret_w_r;
  logic [7:0]                     rd_data_r;

  logic [15:0]                    lw_r, lw_nxt;
  logic [15:0]                    widest_r, widest_nxt;
  logic [15:0]                    hs_r, hs_nxt;
  logic                           caret_r, caret_nxt;

  logic [7:0]                     glyph_w;
  logic [7:0]                     caret_add;
  logic [9:0]                     byte_add;
  logic [16:0]                    lw_sum;
  logic [15:0]                    lw_sat;
  logic [16:0]                    hs_sum;
  logic [15:0]                    hs_sat;
  logic [15:0]                    wide_new;

  logic                           out_valid_r, out_valid_nxt;
  logic [31:0]                    out_data_r;
  logic                           load_out;

  // Hold the pipe while a result waits and another end item is ready
  assign bstat.end_in_b = b_valid_r && (b_kind_r == tem_pkg::KIND_END);
  assign bstat.stall    = bstat.end_in_b && out_valid_r && !out_tready;
  assign adv            = !bstat.stall;
  assign q_pop          = q_valid && adv;

  // Decode the table address
  assign in_rng   = ({1'b0, q_item.code} < 9'(tem_pkg::GLYPH_COUNT));
  assign idx      = q_item.code[tem_pkg::IDX_W-1:0];
  assign do_write = q_pop && (q_item.kind == tem_pkg::KIND_WRITE) && in_rng;
  assign caret_w  = present_r[CARET_IDX] ? caret_adv_r : space_advance;

  // Write and read the advance memory
  always_ff @(posedge clk) begin
    if (do_write) begin
      adv_mem[idx] <= q_item.adv;
    end
    if (q_pop) begin
      rd_data_r <= adv_mem[idx];
    end
  end

  // Present marks and caret shadow copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (do_write) begin
      present_r[idx] <= q_item.pres;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write && (idx == CARET_IDX)) begin
      caret_adv_r <= q_item.adv;
    end
  end

  // Carry the item into the accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_kind_r    <= q_item.kind;
      b_cls_r     <= q_item.cls;
      b_pres_r    <= in_rng && present_r[idx];
      b_caret_w_r <= caret_w;
    end
  end

  // Work out the width added by this item
  always_comb begin
    glyph_w   = b_pres_r ? rd_data_r : space_advance;
    caret_add = caret_r ? b_caret_w_r : 8'd0;
    byte_add  = 10'd0;
    if (b_kind_r == tem_pkg::KIND_TEXT) begin
      case (b_cls_r)
        tem_pkg::CLS_SPACE: byte_add = {2'b00, space_advance};
        tem_pkg::CLS_TAB:   byte_add = {space_advance, 2'b00};
        tem_pkg::CLS_OTHER,
        tem_pkg::CLS_DIGIT: byte_add = {2'b00, glyph_w};
        default:            byte_add = 10'd0;
      endcase
    end
    lw_sum   = {1'b0, lw_r} + 17'(caret_add) + 17'(byte_add);
    lw_sat   = lw_sum[16] ? tem_pkg::SAT16 : lw_sum[15:0];
    hs_sum   = {1'b0, hs_r} + 17'(line_height);
    hs_sat   = hs_sum[16] ? tem_pkg::SAT16 : hs_sum[15:0];
    wide_new = (lw_sat > widest_r) ? lw_sat : widest_r;
  end

  // Update the accumulators
  always_comb begin
    lw_nxt     = lw_r;
    widest_nxt = widest_r;
    hs_nxt     = hs_r;
    caret_nxt  = caret_r;
    load_out   = 1'b0;
    if (b_valid_r && adv) begin
      case (b_kind_r)
        tem_pkg::KIND_TEXT: begin
          if (caret_r && (b_cls_r == tem_pkg::CLS_DIGIT)) begin
            // colour code: drop both bytes
            caret_nxt = 1'b0;
          end else if (b_cls_r == tem_pkg::CLS_NEWLINE) begin
            widest_nxt = wide_new;
            lw_nxt     = 16'd0;
            hs_nxt     = hs_sat;
            caret_nxt  = 1'b0;
          end else begin
            lw_nxt    = lw_sat;
            caret_nxt = (b_cls_r == tem_pkg::CLS_CARET);
          end
        end
        tem_pkg::KIND_END: begin
          load_out   = 1'b1;
          lw_nxt     = 16'd0;
          widest_nxt = 16'd0;
          hs_nxt     = 16'd0;
          caret_nxt  = 1'b0;
        end
        default: begin
          lw_nxt = lw_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r     <= 16'd0;
      widest_r <= 16'd0;
      hs_r     <= 16'd0;
      caret_r  <= 1'b0;
    end else begin
      lw_r     <= lw_nxt;
      widest_r <= widest_nxt;
      hs_r     <= hs_nxt;
      caret_r  <= caret_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {hs_sat, wide_new};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- design/text_extent_measurer_unit.sv -----
// ---------------------------------------------------------------------------
// text_extent_measurer_unit
// Measures the printed width and height of a text stream against a glyph
// table of advances and present marks.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser action; tdata code, advance, present
// out_     out  out_tvalid/out_tready  tdata total_width, total_height
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle is taken while the queue has room; an end item passes
// through the queue and the glyph table read stage, and the accumulate stage
// loads its result into the output register.
// Reset clears present marks, accumulators and control registers.
// in_tready drops only when the four-entry queue is full; the back end holds
// only while a result waits in the output register and another end arrives.
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_extent_measurer_unit_defines.svh"

module text_extent_measurer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,  // char_code[7:0], glyph_advance[15:8],
                                                         // glyph_present[16], zero pad
  input  wire logic [1:0]                    in_tuser,  // action[1:0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata, // total_width[15:0],
                                                         // total_height[31:16]
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  logic            q_valid;
  tem_pkg::item_t  q_item;
  logic            q_pop;
  tem_pkg::bstat_t bstat;
  logic [7:0]      space_advance_r;
  logic [7:0]      line_height_r;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_advance_r <= 8'd0;
      line_height_r   <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tem_pkg::CFG_SPACE_ADVANCE: space_advance_r <= cfg_data;
        tem_pkg::CFG_LINE_HEIGHT:   line_height_r   <= cfg_data;
        default:                    space_advance_r <= space_advance_r;
      endcase
    end
  end

  tem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  tem_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .space_advance (space_advance_r),
    .line_height   (line_height_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .bstat         (bstat)
  );

  // Never pop an empty queue, never pop while the back end holds
  `TEM_ASSERT_NOW(a_pop_has_item, q_pop, q_valid)
  `TEM_ASSERT_NOW(a_no_pop_in_stall, bstat.stall, !q_pop)
  // A new result comes only from an end item in the accumulate stage
  `TEM_ASSERT_NOW(a_result_from_end, $rose(out_tvalid), $past(bstat.end_in_b))

endmodule

`default_nettype wire
